@@ hdl/fbpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and codes for the fixed block pool allocator: command and
// result words, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Width of pool_blocks and of every block count.
  localparam int CNT_W  = 11;
  localparam int ADDR_W = 64;
  localparam int SIZE_W = 32;
  localparam int CFG_W  = 64;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [1:0] CMD_ALLOC     = 2'd0;
  localparam logic [1:0] CMD_FREE      = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIRT_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] addr;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [CNT_W-1:0]  free_blocks;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/fixed_block_pool_allocator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Allocator for a pool of equal blocks: a LIFO chain of freed blocks kept in
// a link memory, on top of untouched blocks handed out in ascending order.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Handshake
//  --------  -----------------------------------  ---------------------------
//  command   start, busy, item                    taken when start && !busy
//  result    done, result                         one-cycle strobe, no stall
//  config    cfg_we, cfg_addr, cfg_wdata          taken when cfg_we
//
//  Every command has an accept cycle, which issues the link memory read at
//  the chain head, and an execute cycle, which uses the read word and
//  updates state. The result strobe rises in the cycle after execute, and
//  busy is low again in that same cycle, so a new word may be accepted then,
//  but not while a word executes; the link memory read is registered.
//  Reset (rst, synchronous) empties the chain and restarts the pool with
//  min(1024, POOL_DEPTH) blocks; the link memory itself is not cleared.
//  The receiver cannot stall; results are never held back.
//
module fixed_block_pool_allocator_core #(
  parameter int POOL_DEPTH  = 1024,
  parameter int BLOCK_SHIFT = 14
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // command side
  input  wire                                  start,
  output logic                                 busy,
  input  fbpa_pkg::item_t                      item,
  // result side
  output logic                                 done,
  output fbpa_pkg::result_t                    result,
  // configuration
  input  wire                                  cfg_we,
  input  wire [fbpa_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire [fbpa_pkg::CFG_W-1:0]            cfg_wdata
);
  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CMP_W = IDX_W + CNT_W;
  localparam logic [SIZE_W:0] BLOCK_BYTES = (SIZE_W+1)'(1) << BLOCK_SHIFT;
  localparam int RESET_POOL = (POOL_DEPTH < 1024) ? POOL_DEPTH : 1024;

  // Configuration registers; pool holds the clamped block count.
  logic [ADDR_W-1:0] virt_base;
  logic [ADDR_W-1:0] phys_base;
  logic [CNT_W-1:0]  pool;

  // Allocator state
  logic [IDX_W-1:0]  freed_head;
  logic              head_valid;
  logic [CNT_W-1:0]  fresh_next;
  logic [CNT_W-1:0]  free_count;

  // Link memory: one entry per block, points to the next freed block.
  logic [IDX_W-1:0]  link_mem [POOL_DEPTH];
  logic [IDX_W-1:0]  link_rd;

  // Command word captured at accept
  logic [1:0]        op;
  logic              too_large;
  logic              addr_ge;
  logic [ADDR_W-1:0] off;
  logic [ADDR_W-1:0] addr_q;

  logic              accept;
  assign accept = start && !busy;

  // Execute-cycle logic
  logic              in_range;
  logic              aligned;
  logic [IDX_W-1:0]  free_idx;
  logic              head_ok;
  logic              fresh_ok;
  logic [IDX_W-1:0]  alloc_idx;
  logic              link_end;
  logic              link_we;
  logic [IDX_W-1:0]  link_wdata;
  logic [ADDR_W-1:0] va_addend;
  logic [ADDR_W-1:0] pa_addend;
  logic [ADDR_W-1:0] va_sum;
  logic [ADDR_W-1:0] pa_sum;
  result_t           result_next;
  logic [IDX_W-1:0]  freed_head_next;
  logic              head_valid_next;
  logic [CNT_W-1:0]  fresh_next_next;
  logic [CNT_W-1:0]  free_count_next;
  logic [CNT_W-1:0]  cfg_pool;

  // Clamp the written block count to 1..POOL_DEPTH.
  always_comb begin
    if (cfg_wdata[CNT_W-1:0] == '0) begin
      cfg_pool = CNT_W'(1);
    end else if (32'(cfg_wdata[CNT_W-1:0]) > 32'(POOL_DEPTH)) begin
      cfg_pool = CNT_W'(POOL_DEPTH);
    end else begin
      cfg_pool = cfg_wdata[CNT_W-1:0];
    end
  end

  always_comb begin
    in_range  = addr_ge && (off[ADDR_W-1:BLOCK_SHIFT+CNT_W] == '0)
                && (off[BLOCK_SHIFT +: CNT_W] < pool);
    aligned   = (off[BLOCK_SHIFT-1:0] == '0);
    free_idx  = off[BLOCK_SHIFT +: IDX_W];
    head_ok   = head_valid && (CMP_W'(freed_head) < CMP_W'(pool));
    fresh_ok  = (fresh_next < pool);
    alloc_idx = head_ok ? freed_head : IDX_W'(fresh_next);
    // A link to itself or outside the pool ends the chain.
    link_end  = (link_rd == freed_head) || (CMP_W'(link_rd) >= CMP_W'(pool));

    // Two shared adders: base plus block offset or address offset.
    if (op == CMD_TRANSLATE) begin
      va_addend = {off[ADDR_W-1:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}};
      pa_addend = off;
    end else begin
      va_addend = ADDR_W'(alloc_idx) << BLOCK_SHIFT;
      pa_addend = ADDR_W'(alloc_idx) << BLOCK_SHIFT;
    end
    va_sum = virt_base + va_addend;
    pa_sum = phys_base + pa_addend;

    freed_head_next = freed_head;
    head_valid_next = head_valid;
    fresh_next_next = fresh_next;
    free_count_next = free_count;
    link_we         = 1'b0;
    link_wdata      = head_valid ? freed_head : free_idx;
    result_next.status    = ST_BAD_ADDR;
    result_next.virt_addr = '0;
    result_next.phys_addr = '0;

    unique case (op)
      CMD_ALLOC: begin
        if (too_large) begin
          result_next.status = ST_TOO_LARGE;
        end else if (head_ok || fresh_ok) begin
          // Pop the chain first, then take untouched blocks.
          if (head_ok) begin
            if (link_end) begin
              head_valid_next = 1'b0;
            end else begin
              freed_head_next = link_rd;
            end
          end else begin
            fresh_next_next = fresh_next + CNT_W'(1);
          end
          result_next.status    = ST_OK;
          result_next.virt_addr = va_sum;
          result_next.phys_addr = pa_sum;
          if (free_count != '0) begin
            free_count_next = free_count - CNT_W'(1);
          end
        end else begin
          result_next.status = ST_EXHAUSTED;
        end
      end
      CMD_FREE: begin
        if (in_range && aligned) begin
          // Push onto the chain; the first block links to itself.
          link_we         = 1'b1;
          freed_head_next = free_idx;
          head_valid_next = 1'b1;
          if (free_count < pool) begin
            free_count_next = free_count + CNT_W'(1);
          end
          result_next.status    = ST_OK;
          result_next.virt_addr = addr_q;
        end
      end
      CMD_TRANSLATE: begin
        if (in_range) begin
          result_next.status    = ST_OK;
          result_next.virt_addr = va_sum;
          result_next.phys_addr = pa_sum;
        end
      end
      default: begin
        // Unknown command: bad address, nothing changes.
      end
    endcase
    result_next.free_blocks = free_count_next;
  end

  // Link memory: read at accept, write back in the execute cycle. A write
  // lands before the next read can be issued, so no forwarding.
  always_ff @(posedge clk) begin
    if (accept) begin
      link_rd <= link_mem[freed_head];
    end
    if (busy && link_we) begin
      link_mem[free_idx] <= link_wdata;
    end
  end

  // Capture the command word; the wide subtract is done here.
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= item.cmd;
      too_large <= ({1'b0, item.req_size} > BLOCK_BYTES);
      addr_ge   <= (item.addr >= virt_base);
      off       <= item.addr - virt_base;
      addr_q    <= item.addr;
    end
  end

  // Result word: loaded in the execute cycle, held until the next execute.
  always_ff @(posedge clk) begin
    if (busy) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      virt_base  <= '0;
      phys_base  <= '0;
      pool       <= CNT_W'(RESET_POOL);
      freed_head <= '0;
      head_valid <= 1'b0;
      fresh_next <= '0;
      free_count <= CNT_W'(RESET_POOL);
    end else begin
      done <= busy;
      busy <= accept;
      if (busy) begin
        freed_head <= freed_head_next;
        head_valid <= head_valid_next;
        fresh_next <= fresh_next_next;
        free_count <= free_count_next;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_VIRT_BASE: virt_base <= cfg_wdata;
          CFG_PHYS_BASE: phys_base <= cfg_wdata;
          CFG_POOL_BLOCKS: begin
            // Restart the pool: drop the chain, rewind untouched blocks.
            pool       <= cfg_pool;
            freed_head <= '0;
            head_valid <= 1'b0;
            fresh_next <= '0;
            free_count <= cfg_pool;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/fbpa_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the fixed block pool allocator core.
// ----------------------------------------------------------------------------
module fbpa_checker (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input wire               busy,
  input wire               done,
  input fbpa_pkg::result_t result
);
  import fbpa_pkg::*;

  // An accepted word yields a result strobe after its execute cycle.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("no result two cycles after accept");

  // Execute lasts one cycle.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // A result strobe follows only an execute cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without execute");

  // Failed commands give zero addresses.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.virt_addr == '0 && result.phys_addr == '0))
    else $error("failed command returned an address");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
